// ===== design/rv32i_immediate_load_jump_exec_top_assert.svh =====
// Assertion macros used by the checker file of the I-type execute block.
// Needs clk_i and rst_ni in scope at every use.
`ifndef RV32I_IMMEDIATE_LOAD_JUMP_EXEC_TOP_ASSERT_SVH
`define RV32I_IMMEDIATE_LOAD_JUMP_EXEC_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RVIE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define RVIE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rvie_pkg.sv =====
// Shared types and constants of the RV32I I-type execute block.
// No dependencies; used by every module of the block but rvie_ram.
`timescale 1ns / 1ps
`default_nettype none

package rvie_pkg;

  localparam int unsigned MEM_BYTES_DEF = 1024;
  localparam int unsigned IN_TDATA_W    = 56;
  localparam int unsigned OUT_TDATA_W   = 72;

  typedef enum logic [6:0] {
    OPC_LOAD = 7'b0000011,
    OPC_ALUI = 7'b0010011,
    OPC_JALR = 7'b1100111
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOTIMP  = 2'd1,
    ST_RANGE   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  // ALU immediate group
  localparam logic [2:0] F3_ADDI  = 3'd0;
  localparam logic [2:0] F3_SLTI  = 3'd2;
  localparam logic [2:0] F3_SLTIU = 3'd3;
  localparam logic [2:0] F3_XORI  = 3'd4;
  localparam logic [2:0] F3_ORI   = 3'd6;
  localparam logic [2:0] F3_ANDI  = 3'd7;
  // loads
  localparam logic [2:0] F3_LB    = 3'd0;
  localparam logic [2:0] F3_LH    = 3'd1;
  localparam logic [2:0] F3_LW    = 3'd2;
  localparam logic [2:0] F3_LBU   = 3'd4;
  localparam logic [2:0] F3_LHU   = 3'd5;
  // jalr
  localparam logic [2:0] F3_JALR  = 3'd0;

  localparam logic [31:0] SEXT_B_MASK = 32'hFFFFFF00;
  localparam logic [31:0] SEXT_H_MASK = 32'hFFFF0000;

  // Data memory access issued by the execute stage
  typedef struct packed {
    logic        rd_en;
    logic [31:0] rd_addr;
    logic        wr_en;
    logic [9:0]  wr_addr;
    logic [7:0]  wr_byte;
  } dmem_req_t;

endpackage

`default_nettype wire

// ===== design/rvie_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rvie_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/rvie_dmem.sv =====
// Byte data memory in four byte-lane banks, with a clearing sweep after reset.
// Depends on rvie_pkg and rvie_ram.
`timescale 1ns / 1ps
`default_nettype none

module rvie_dmem #(
  parameter int unsigned MEM_BYTES = rvie_pkg::MEM_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rvie_pkg::dmem_req_t req_i,
  output logic                     busy_o,
  output logic [31:0]              word_o
);

  import rvie_pkg::*;

  localparam int unsigned ROWS = (MEM_BYTES + 3) / 4;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic          busy_q;
  logic [RW-1:0] clr_cnt_q;
  logic [1:0]    alo_q;
  logic [7:0]    bank_rd [4];
  logic [31:0]   pa32;

  assign busy_o = busy_q;
  assign pa32   = {22'b0, req_i.wr_addr};

  // clear sweep: one row of all four banks per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      if (clr_cnt_q == RW'(ROWS - 1)) begin
        busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      alo_q <= req_i.rd_addr[1:0];
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]    ofs;
    logic [31:0]   baddr;
    logic [29:0]   row_full;
    logic [RW-1:0] rrow;
    logic [RW-1:0] wrow;
    logic          we;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;

    // byte of the access that lands in this lane, and its row
    assign ofs      = 2'(b) - req_i.rd_addr[1:0];
    assign baddr    = req_i.rd_addr + {30'b0, ofs};
    assign row_full = baddr[31:2];
    assign rrow     = (row_full < 30'(ROWS)) ? row_full[RW-1:0] : '0;
    assign wrow     = pa32[RW+1:2];
    assign we       = busy_q | (req_i.wr_en && (req_i.wr_addr[1:0] == 2'(b)));
    assign waddr    = busy_q ? clr_cnt_q : wrow;
    assign wdata    = busy_q ? 8'h00 : req_i.wr_byte;

    rvie_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (req_i.rd_en),
      .raddr_i (rrow),
      .rdata_o (bank_rd[b])
    );
  end

  // rotate lanes so byte i of the access sits at bits 8i
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      word_o[8*i +: 8] = bank_rd[alo_q + 2'(i)];
    end
  end

endmodule

`default_nettype wire

// ===== design/rv32i_immediate_load_jump_exec_top.sv =====
// Top level of the RV32I I-type execute block: register file, PC, pipeline.
// Depends on rvie_pkg, rvie_ram and rvie_dmem.
//
// Usage:
//   Input beats arrive on the s_axis group. tuser carries cmd: 0 executes
//   one decoded I-type instruction (addi, slti, sltiu, xori, ori, andi,
//   lb, lh, lw, lbu, lhu, jalr), 1 preloads one byte into data memory.
//   Every input beat yields exactly one result beat on the m_axis group
//   with status, the register write done (if any) and the PC afterwards.
//   Pipeline: register file read, execute plus data memory read, write
//   back, in that order. Throughput: one beat per cycle unless stalled;
//   the register file and data memory are synchronous RAMs, with
//   forwarding from write back into execute, so a dependent instruction,
//   a load included, may follow directly.
//   Reset: the PC and the register file valid bits clear at once; the
//   data memory is then swept clear, one 4-byte row per cycle, over all
//   (MEM_BYTES+3)/4 rows, with s_axis_tready low for that time.
//   Stall: when m_axis_tready is low the result beat holds; up to three
//   beats stay in flight before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_immediate_load_jump_exec_top #(
  parameter int unsigned MEM_BYTES = rvie_pkg::MEM_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // opcode[6:0], func3[9:7], dest_index[14:10], src_index[19:15],
  // immediate[31:20], preload_addr[41:32], preload_byte[49:42], zero fill
  input  wire logic [rvie_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd[0]
  input  wire logic [0:0]                       s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // status[1:0], reg_written[2], written_index[7:3],
  // written_value[39:8], next_pc[71:40]
  output logic [rvie_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o
);

  import rvie_pkg::*;

  // handshake / flow
  logic accept, out_free, s2_free, s1_free, s1_move, s2_move;
  logic dmem_busy;
  logic [4:0] in_rs1;

  // stage 1: operand fetch done, execute
  logic        s1_v_q, s1_cmd_q, s1_rfv_q;
  logic [6:0]  s1_opc_q;
  logic [2:0]  s1_f3_q;
  logic [4:0]  s1_rd_q, s1_rs1_q;
  logic [11:0] s1_imm_q;
  logic [9:0]  s1_paddr_q;
  logic [7:0]  s1_pbyte_q;
  logic        byp_hit_q;
  logic [31:0] byp_val_q;

  // stage 2: load data returns, write back
  logic        s2_v_q, s2_wr_q, s2_load_q;
  status_e     s2_status_q;
  logic [4:0]  s2_idx_q;
  logic [31:0] s2_val_q, s2_pc_q;
  logic [2:0]  s2_f3_q;

  // output register
  logic        out_v_q, out_wr_q;
  status_e     out_status_q;
  logic [4:0]  out_idx_q;
  logic [31:0] out_val_q, out_pc_q;

  logic [31:0] pc_q;
  logic [31:0] rf_valid_q;
  logic [31:0] rf_rdata;
  logic        rf_we;

  // execute results
  logic [31:0] op, imm32, sum, pc4, val, pc_n, val_f, s2_val_fin, load_word;
  logic        wr, is_load, mem_rd, mem_wr, wr_f, load_f;
  logic [2:0]  sz;
  status_e     st;
  dmem_req_t   dreq;

  assign in_rs1   = s_axis_tdata_i[19:15];

  assign out_free = !out_v_q || m_axis_tready_i;
  assign s2_free  = !s2_v_q || out_free;
  assign s1_free  = !s1_v_q || s2_free;
  assign s1_move  = s1_v_q && s2_free;
  assign s2_move  = s2_v_q && out_free;

  // hold input off during the clear sweep
  assign s_axis_tready_o = !dmem_busy && s1_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------- regfile
  assign rf_we = s2_move && s2_wr_q;

  rvie_ram #(
    .WIDTH (32),
    .DEPTH (32)
  ) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_idx_q),
    .wdata_i (s2_val_fin),
    .re_i    (accept),
    .raddr_i (in_rs1),
    .rdata_o (rf_rdata)
  );

  // ---------------------------------------------------------------- execute
  // Operand: forward from write back, then from the write that collided
  // with the read, then the RAM; never-written entries read zero.
  always_comb begin
    if (s1_rs1_q == 5'd0) begin
      op = 32'h0;
    end else if (s2_v_q && s2_wr_q && (s2_idx_q == s1_rs1_q)) begin
      op = s2_val_fin;
    end else if (byp_hit_q) begin
      op = byp_val_q;
    end else if (s1_rfv_q) begin
      op = rf_rdata;
    end else begin
      op = 32'h0;
    end
  end

  assign imm32 = {{20{s1_imm_q[11]}}, s1_imm_q};
  assign sum   = op + imm32;
  assign pc4   = pc_q + 32'd4;

  always_comb begin
    st      = ST_OK;
    wr      = 1'b0;
    val     = 32'h0;
    is_load = 1'b0;
    mem_rd  = 1'b0;
    mem_wr  = 1'b0;
    pc_n    = pc_q;
    sz      = 3'd0;
    if (s1_cmd_q) begin
      // preload: drop bytes beyond the memory
      mem_wr = ({22'b0, s1_paddr_q} < 32'(MEM_BYTES));
    end else begin
      unique case (s1_opc_q)
        OPC_ALUI: begin
          wr = 1'b1;
          unique case (s1_f3_q)
            F3_ADDI:  val = sum;
            F3_SLTI:  val = {31'b0, $signed(op) < $signed(imm32)};
            F3_SLTIU: val = {31'b0, op < imm32};
            F3_XORI:  val = op ^ imm32;
            F3_ORI:   val = op | imm32;
            F3_ANDI:  val = op & imm32;
            default: begin
              wr = 1'b0;
              st = ST_NOTIMP;
            end
          endcase
          if (st == ST_OK) begin
            pc_n = pc4;
          end
        end
        OPC_LOAD: begin
          unique case (s1_f3_q) inside
            F3_LB, F3_LBU: sz = 3'd1;
            F3_LH, F3_LHU: sz = 3'd2;
            F3_LW:         sz = 3'd4;
            default:       sz = 3'd0;
          endcase
          if (sz == 3'd0) begin
            st = ST_NOTIMP;
          end else if (({1'b0, sum} + {30'b0, sz}) > 33'(MEM_BYTES)) begin
            st = ST_RANGE;
          end else begin
            wr      = 1'b1;
            is_load = 1'b1;
            mem_rd  = 1'b1;
            pc_n    = pc4;
          end
        end
        OPC_JALR: begin
          if (s1_f3_q != F3_JALR) begin
            st = ST_NOTIMP;
          end else begin
            wr   = 1'b1;
            val  = pc4;
            pc_n = {sum[31:1], 1'b0};
          end
        end
        default: st = ST_IGNORED;
      endcase
    end
  end

  // x0 absorbs writes and the result then reports no write
  assign wr_f   = wr && (s1_rd_q != 5'd0);
  assign load_f = is_load && (s1_rd_q != 5'd0);
  assign val_f  = wr_f ? val : 32'h0;

  assign dreq.rd_en   = s1_move && mem_rd;
  assign dreq.rd_addr = sum;
  assign dreq.wr_en   = s1_move && mem_wr;
  assign dreq.wr_addr = s1_paddr_q;
  assign dreq.wr_byte = s1_pbyte_q;

  rvie_dmem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dmem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .busy_o (dmem_busy),
    .word_o (load_word)
  );

  // ------------------------------------------------------------- write back
  always_comb begin
    if (s2_load_q) begin
      unique case (s2_f3_q)
        F3_LB:  s2_val_fin = {{24{load_word[7]}}, load_word[7:0]};
        F3_LH:  s2_val_fin = {{16{load_word[15]}}, load_word[15:0]};
        F3_LBU: s2_val_fin = load_word & ~SEXT_B_MASK;
        F3_LHU: s2_val_fin = load_word & ~SEXT_H_MASK;
        default: s2_val_fin = load_word;
      endcase
    end else begin
      s2_val_fin = s2_val_q;
    end
  end

  // ---------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      pc_q       <= 32'h0;
      rf_valid_q <= '0;
      byp_hit_q  <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= accept;
      end
      if (s2_free) begin
        s2_v_q <= s1_move;
      end
      if (out_free) begin
        out_v_q <= s2_move;
      end
      if (s1_move) begin
        pc_q <= pc_n;
      end
      if (rf_we) begin
        rf_valid_q[s2_idx_q] <= 1'b1;
      end
      // remember a write landing on the same edge as the operand read
      if (accept) begin
        byp_hit_q <= rf_we && (s2_idx_q == in_rs1);
      end
    end
  end

  // ----------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= s_axis_tuser_i[0];
      s1_opc_q   <= s_axis_tdata_i[6:0];
      s1_f3_q    <= s_axis_tdata_i[9:7];
      s1_rd_q    <= s_axis_tdata_i[14:10];
      s1_rs1_q   <= in_rs1;
      s1_imm_q   <= s_axis_tdata_i[31:20];
      s1_paddr_q <= s_axis_tdata_i[41:32];
      s1_pbyte_q <= s_axis_tdata_i[49:42];
      s1_rfv_q   <= rf_valid_q[in_rs1];
      byp_val_q  <= s2_val_fin;
    end
    if (s1_move) begin
      s2_status_q <= st;
      s2_wr_q     <= wr_f;
      s2_load_q   <= load_f;
      s2_idx_q    <= wr_f ? s1_rd_q : 5'd0;
      s2_val_q    <= val_f;
      s2_f3_q     <= s1_f3_q;
      s2_pc_q     <= pc_n;
    end
    if (s2_move) begin
      out_status_q <= s2_status_q;
      out_wr_q     <= s2_wr_q;
      out_idx_q    <= s2_idx_q;
      out_val_q    <= s2_val_fin;
      out_pc_q     <= s2_pc_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_pc_q, out_val_q, out_idx_q, out_wr_q, out_status_q};

endmodule

`default_nettype wire

// ===== design/rvie_checker.sv =====
// Port-level checker for the I-type execute block, bound to its top level.
// Depends on rvie_pkg and rv32i_immediate_load_jump_exec_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "rv32i_immediate_load_jump_exec_top_assert.svh"

module rvie_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_axis_tvalid_i,
  input wire logic                              m_axis_tready_i,
  input wire logic [rvie_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_i
);

  import rvie_pkg::*;

  // a stalled result beat holds
  `RVIE_ASSERT_NXT(a_out_hold, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i), "result beat changed while stalled")

  // no register write: index and value read zero
  `RVIE_ASSERT_IMP(a_no_write_clean, m_axis_tvalid_i && !m_axis_tdata_i[2], m_axis_tdata_i[39:3] == '0, "index or value set without a register write")

  // a register write only comes with ok status and never targets x0
  `RVIE_ASSERT_IMP(a_write_ok, m_axis_tvalid_i && m_axis_tdata_i[2], m_axis_tdata_i[1:0] == ST_OK && m_axis_tdata_i[7:3] != 5'd0, "register write with bad status or to x0")

endmodule

bind rv32i_immediate_load_jump_exec_top rvie_checker u_rvie_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

`default_nettype wire

// ===== tb/tb_rv32i_immediate_load_jump_exec_top.sv =====
// Testbench for the RV32I I-type execute block: directed and random beats
// checked against an in-bench predictor of registers, PC and data memory.
// Depends on rvie_pkg and the RTL of rv32i_immediate_load_jump_exec_top.
`timescale 1ns / 1ps

module tb_rv32i_immediate_load_jump_exec_top;
  import rvie_pkg::*;

  localparam int unsigned DMEM_BYTES  = MEM_BYTES_DEF;
  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned IDLE_PCT    = 27;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  // func3 codes the block must reject, and opcodes it must ignore
  localparam logic [2:0] F3_SLLI      = 3'd1;
  localparam logic [2:0] F3_SRXI      = 3'd5;
  localparam logic [2:0] F3_LD        = 3'd3;
  localparam logic [2:0] F3_LWU       = 3'd6;
  localparam logic [2:0] F3_LOAD_RSVD = 3'd7;
  localparam logic [2:0] F3_JALR_BAD  = 3'd1;
  localparam logic [6:0] OPC_LUI      = 7'b0110111;
  localparam logic [6:0] OPC_ZERO     = 7'b0000000;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  opcode;
    logic [2:0]  func3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [11:0] imm;
    logic [9:0]  paddr;
    logic [7:0]  pbyte;
  } exec_item_t;

  // laid out as m_axis_tdata_o: next_pc in the top bits, status in the lowest
  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] val;
    logic [4:0]  idx;
    logic        wr;
    logic [1:0]  status;
  } exec_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic [0:0]             s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Shadow architectural state of the block
  logic [31:0] gpr_shadow [32];
  logic [31:0] pc_shadow;
  logic [7:0]  dmem_shadow [DMEM_BYTES];

  exec_result_t pending_results [$];

  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned fail_count;
  bit          src_idle_en;
  bit          sink_idle_en;
  bit          hold_req;

  rv32i_immediate_load_jump_exec_top #(
    .MEM_BYTES(DMEM_BYTES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run one item against the shadow state and return what the block must report.
  function automatic exec_result_t predict_exec(exec_item_t it);
    exec_result_t res;
    logic [31:0]  imm_x;
    logic [31:0]  src;
    logic [31:0]  addr;
    int unsigned  nbytes;

    res    = '0;
    res.status = ST_OK;
    imm_x  = {{20{it.imm[11]}}, it.imm};
    src    = (it.rs1 == 5'd0) ? 32'd0 : gpr_shadow[it.rs1];
    nbytes = 0;

    if (it.cmd) begin
      if (it.paddr < DMEM_BYTES) dmem_shadow[it.paddr] = it.pbyte;
    end else if (it.opcode == OPC_ALUI) begin
      res.wr = 1'b1;
      case (it.func3)
        F3_ADDI:  res.val = src + imm_x;
        F3_SLTI:  res.val = {31'd0, $signed(src) < $signed(imm_x)};
        F3_SLTIU: res.val = {31'd0, src < imm_x};
        F3_XORI:  res.val = src ^ imm_x;
        F3_ORI:   res.val = src | imm_x;
        F3_ANDI:  res.val = src & imm_x;
        default: begin
          res.wr     = 1'b0;
          res.status = ST_NOTIMP;
        end
      endcase
      if (res.status == ST_OK) pc_shadow = pc_shadow + 32'd4;
    end else if (it.opcode == OPC_LOAD) begin
      case (it.func3)
        F3_LB, F3_LBU: nbytes = 1;
        F3_LH, F3_LHU: nbytes = 2;
        F3_LW:         nbytes = 4;
        default:       nbytes = 0;
      endcase
      addr = src + imm_x;
      if (nbytes == 0) begin
        res.status = ST_NOTIMP;
      end else if (64'(addr) + 64'(nbytes) > 64'(DMEM_BYTES)) begin
        res.status = ST_RANGE;
      end else begin
        // assemble little-endian, byte by byte, so misaligned reads work
        for (int i = 0; i < nbytes; i++) res.val |= 32'(dmem_shadow[addr + i]) << (8 * i);
        if (it.func3 == F3_LB && res.val[7])  res.val |= SEXT_B_MASK;
        if (it.func3 == F3_LH && res.val[15]) res.val |= SEXT_H_MASK;
        res.wr    = 1'b1;
        pc_shadow = pc_shadow + 32'd4;
      end
    end else if (it.opcode == OPC_JALR) begin
      if (it.func3 != F3_JALR) begin
        res.status = ST_NOTIMP;
      end else begin
        // target from the old rs1, so rd equal to rs1 links afterwards
        res.val   = pc_shadow + 32'd4;
        res.wr    = 1'b1;
        pc_shadow = (src + imm_x) & 32'hFFFF_FFFE;
      end
    end else begin
      res.status = ST_IGNORED;
    end

    if (res.wr && it.rd != 5'd0) begin
      gpr_shadow[it.rd] = res.val;
      res.idx = it.rd;
    end else begin
      res.wr  = 1'b0;
      res.val = '0;
      res.idx = '0;
    end
    res.pc = pc_shadow;
    return res;
  endfunction

  function automatic exec_item_t instr(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                       logic [4:0] rs1, int imm_val);
    exec_item_t it;
    it        = '0;
    it.opcode = opc;
    it.func3  = f3;
    it.rd     = rd;
    it.rs1    = rs1;
    it.imm    = imm_val[11:0];
    return it;
  endfunction

  function automatic exec_item_t preload(logic [9:0] addr, logic [7:0] data);
    exec_item_t it;
    it       = '0;
    it.cmd   = 1'b1;
    it.paddr = addr;
    it.pbyte = data;
    return it;
  endfunction

  // Mostly well-formed instructions with random content, some preloads and noise.
  function automatic exec_item_t random_item();
    exec_item_t  it;
    logic [63:0] bits;
    logic [31:0] near;
    int unsigned roll;

    bits = {$urandom, $urandom};
    it   = bits[$bits(exec_item_t)-1:0];
    roll = $urandom_range(99);
    if (roll < 15) begin
      it.cmd = 1'b1;
    end else if (roll < 85) begin
      it.cmd = 1'b0;
      roll   = $urandom_range(9);
      if (roll < 4) begin
        it.opcode = OPC_ALUI;
        case ($urandom_range(5))
          0:       it.func3 = F3_ADDI;
          1:       it.func3 = F3_SLTI;
          2:       it.func3 = F3_SLTIU;
          3:       it.func3 = F3_XORI;
          4:       it.func3 = F3_ORI;
          default: it.func3 = F3_ANDI;
        endcase
      end else if (roll < 8) begin
        it.opcode = OPC_LOAD;
        case ($urandom_range(4))
          0:       it.func3 = F3_LB;
          1:       it.func3 = F3_LH;
          2:       it.func3 = F3_LW;
          3:       it.func3 = F3_LBU;
          default: it.func3 = F3_LHU;
        endcase
        // aim most loads at memory, straddling the top edge now and then
        if ($urandom_range(99) < 60) begin
          near   = $urandom_range(DMEM_BYTES + 3);
          it.rs1 = 5'd0;
          it.imm = near[11:0];
        end
      end else begin
        it.opcode = OPC_JALR;
        it.func3  = F3_JALR;
      end
    end else begin
      it.cmd = 1'b0;
    end
    return it;
  endfunction

  // Offer one beat, wait for the handshake, record its expected result.
  // Enter and leave at a falling edge.
  task automatic send_beat(exec_item_t it);
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= it.cmd;
    s_axis_tdata_i  <= {6'd0, it.pbyte, it.paddr, it.imm, it.rs1, it.rd, it.func3, it.opcode};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(predict_exec(it));
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic test_alu_immediate();
    send_beat(instr(OPC_ALUI, F3_ADDI, 5'd1, 5'd0, 2047));
    send_beat(instr(OPC_ALUI, F3_ADDI, 5'd2, 5'd0, -2048));
    send_beat(instr(OPC_ALUI, F3_SLTI, 5'd3, 5'd2, -1));
    send_beat(instr(OPC_ALUI, F3_SLTIU, 5'd4, 5'd1, -1));
    send_beat(instr(OPC_ALUI, F3_XORI, 5'd5, 5'd2, -1));
    send_beat(instr(OPC_ALUI, F3_ORI, 5'd6, 5'd1, -2048));
    send_beat(instr(OPC_ALUI, F3_ANDI, 5'd7, 5'd6, 'h555));
    // write to x0 is dropped, PC still advances
    send_beat(instr(OPC_ALUI, F3_ADDI, 5'd0, 5'd1, 1));
    send_beat(instr(OPC_ALUI, F3_SLLI, 5'd8, 5'd1, 3));
    send_beat(instr(OPC_ALUI, F3_SRXI, 5'd8, 5'd1, 3));
  endtask

  task automatic test_loads();
    send_beat(preload(10'd1020, 8'h80));
    send_beat(preload(10'd1021, 8'h01));
    send_beat(preload(10'd1022, 8'hFE));
    send_beat(preload(10'd1023, 8'h7F));
    send_beat(instr(OPC_LOAD, F3_LB, 5'd9, 5'd0, 1020));
    send_beat(instr(OPC_LOAD, F3_LBU, 5'd10, 5'd0, 1020));
    send_beat(instr(OPC_LOAD, F3_LH, 5'd11, 5'd0, 1021));   // misaligned, negative
    send_beat(instr(OPC_LOAD, F3_LHU, 5'd12, 5'd0, 1021));
    send_beat(instr(OPC_LOAD, F3_LW, 5'd13, 5'd0, 1020));
    send_beat(instr(OPC_LOAD, F3_LW, 5'd14, 5'd0, 1021));   // runs past the top
    send_beat(instr(OPC_LOAD, F3_LB, 5'd15, 5'd2, 0));      // wraps to a huge address
    send_beat(instr(OPC_LOAD, F3_LD, 5'd15, 5'd0, 0));
    send_beat(instr(OPC_LOAD, F3_LWU, 5'd15, 5'd0, 0));
    send_beat(instr(OPC_LOAD, F3_LOAD_RSVD, 5'd15, 5'd0, 0));
  endtask

  task automatic test_jalr_and_ignored();
    send_beat(instr(OPC_JALR, F3_JALR, 5'd16, 5'd1, 1));    // target x1 + 1 is already even
    send_beat(instr(OPC_JALR, F3_JALR, 5'd1, 5'd1, 0));     // rd equal to rs1
    send_beat(instr(OPC_JALR, F3_JALR, 5'd0, 5'd0, -2));    // link to x0
    send_beat(instr(OPC_JALR, F3_JALR_BAD, 5'd17, 5'd0, 4));
    send_beat(instr(OPC_LUI, F3_ADDI, 5'd17, 5'd1, 5));
    send_beat(instr(OPC_ZERO, F3_ADDI, 5'd17, 5'd1, 5));
  endtask

  // Stall the result side long enough that the block backs up into its input.
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_req     = 1'b1;
    repeat (24) send_beat(random_item());
  endtask

  task automatic test_random(int unsigned n_steady, int unsigned n_idle);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (n_steady) send_beat(random_item());
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (n_idle) send_beat(random_item());
  endtask

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what,
               exp_v, got_v);
  endtask

  // Compare every accepted result beat with the oldest pending prediction.
  always @(posedge clk_i) begin : check_results
    exec_result_t got;
    exec_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 32'd0, got.pc);
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (got.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(got.status));
        if (got.wr !== want.wr)
          report_mismatch("reg_written", 32'(want.wr), 32'(got.wr));
        if (got.idx !== want.idx)
          report_mismatch("written_index", 32'(want.idx), 32'(got.idx));
        if (got.val !== want.val)       report_mismatch("written_value", want.val, got.val);
        if (got.pc !== want.pc)         report_mismatch("next_pc", want.pc, got.pc);
      end
    end
  end

  // Result side: random idling, plus a counted hold-off when a test asks.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left       = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (sink_idle_en && $urandom_range(99) < IDLE_PCT) begin
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(4_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin : run_tests
    int unsigned waited;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    beats_sent      = 0;
    beats_checked   = 0;
    fail_count      = 0;
    src_idle_en     = 1'b1;
    sink_idle_en    = 1'b1;
    hold_req        = 1'b0;
    pc_shadow       = '0;
    foreach (gpr_shadow[i]) gpr_shadow[i] = '0;
    foreach (dmem_shadow[i]) dmem_shadow[i] = '0;

    // Hold reset, then release it on a falling edge
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_alu_immediate();
    test_loads();
    test_jalr_and_ignored();
    test_backpressure();
    test_random(150, 500);

    // Drop valid, then let every pending result drain
    s_axis_tvalid_i <= 1'b0;
    sink_idle_en = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0d predicted results never arrived", pending_results.size());
    end
    $display("Ran %0d beats (ALU immediate, loads, jalr, preloads, ignored opcodes)",
             beats_sent);
    $display("Checked %0d results with idling, a long output stall and back-pressure",
             beats_checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
